### design/csdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdf_pkg: shared types and constants of the call-site delay filter
// Slot layout, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package csdf_pkg;

  localparam int ADDR_W     = 64;
  localparam int LIMIT_W    = 10;
  localparam int CNT_W      = 10;
  localparam int CLASS_W    = 2;
  localparam int SLOTS_DEF  = 256;

  // hash = (a >> 4) ^ (a >> 13), 60 significant bits
  localparam int SHIFT_LO   = 4;
  localparam int SHIFT_HI   = 13;
  localparam int HASH_W     = ADDR_W - SHIFT_LO;
  localparam int HASH_DIGIT = 4;
  localparam int HASH_STEPS = HASH_W / HASH_DIGIT;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_MATCH = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  key;
    logic [CLASS_W-1:0] cls;
    logic [CNT_W-1:0]   cnt;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic hash_step;
    logic start_probe;
    logic advance;
    logic commit;
    logic set_full;
    logic emit;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic qualifies;
    logic hash_done;
    logic hit;
    logic last_probe;
    logic out_free;
  } stat_t;

endpackage

### design/csdf_query_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdf_query_if: timer query channel
// Valid/ready channel carrying one query per transfer.
// ----------------------------------------------------------------------------
interface csdf_query_if;
  logic                        valid;
  logic                        ready;
  logic [csdf_pkg::ADDR_W-1:0] caller_address;
  logic                        call_ok;
  logic                        is_monotonic;
  logic                        module_matches;

  modport source (
    output valid, caller_address, call_ok, is_monotonic, module_matches,
    input  ready
  );
  modport sink (
    input  valid, caller_address, call_ok, is_monotonic, module_matches,
    output ready
  );
endinterface

### design/csdf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdf_result_if: delay decision channel
// Valid/ready channel carrying one decision per transfer.
// ----------------------------------------------------------------------------
interface csdf_result_if;
  logic valid;
  logic ready;
  logic delay;
  logic table_full;
  logic newly_classified;

  modport source (
    output valid, delay, table_full, newly_classified,
    input  ready
  );
  modport sink (
    input  valid, delay, table_full, newly_classified,
    output ready
  );
endinterface

### design/csdf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdf_datapath: slot table, hash reduction and result register
// Holds the slot memory, probe pointer, limit register and output stage.
// ----------------------------------------------------------------------------
module csdf_datapath #(
  parameter int SLOTS = csdf_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [csdf_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic [csdf_pkg::ADDR_W-1:0]  caller_address,
  input  logic                         call_ok,
  input  logic                         is_monotonic,
  input  logic                         module_matches,
  input  csdf_pkg::ctrl_t              ctrl,
  output csdf_pkg::stat_t              stat,
  csdf_result_if.source                result
);
  import csdf_pkg::*;

  localparam int  IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam bit  POW2  = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int  STEP_W = $clog2(HASH_STEPS + 1);
  localparam logic [IDX_W:0]   SLOTS_T  = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  slot_t mem [SLOTS];
  slot_t rd_data;
  slot_t wr_data;

  logic [LIMIT_W-1:0] delay_limit;
  logic [ADDR_W-1:0]  addr;
  logic               match;
  logic [HASH_W-1:0]  hx;
  logic [IDX_W-1:0]   rem;
  logic [IDX_W-1:0]   rem_next;
  logic [STEP_W-1:0]  step;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   probes;
  logic               pend_delay, pend_full, pend_fresh;
  logic               out_valid, out_delay, out_full, out_fresh;

  logic [HASH_W-1:0]  hash_in;
  logic               key_empty, key_hit;
  logic [CLASS_W-1:0] cls_new;
  logic               fresh, is_match, delay_now;
  logic [CNT_W-1:0]   cnt_new;

  assign hash_in = caller_address[ADDR_W-1:SHIFT_LO]
                 ^ {{(SHIFT_HI - SHIFT_LO){1'b0}}, caller_address[ADDR_W-1:SHIFT_HI]};

  // one remainder digit a cycle: four restoring steps
  always_comb begin
    logic [IDX_W:0] t;
    t = '0;
    rem_next = rem;
    for (int k = 0; k < HASH_DIGIT; k++) begin
      t = {rem_next, hx[HASH_W - 1 - k]};
      if (t >= SLOTS_T) t = t - SLOTS_T;
      rem_next = t[IDX_W-1:0];
    end
  end

  assign idx_inc = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);

  // slot update
  assign key_empty = (rd_data.key == '0);
  assign key_hit   = (rd_data.key == addr);
  assign fresh     = (rd_data.cls == CLASS_NONE);
  assign cls_new   = fresh ? (match ? CLASS_MATCH : CLASS_OTHER) : rd_data.cls;
  assign is_match  = (cls_new == CLASS_MATCH);
  assign delay_now = is_match && (rd_data.cnt < delay_limit);
  assign cnt_new   = (is_match && rd_data.cnt != CNT_MAX) ? rd_data.cnt + CNT_W'(1)
                                                          : rd_data.cnt;

  always_comb begin
    wr_data = '0;
    if (!ctrl.clear_wr) begin
      wr_data.key = addr;
      wr_data.cls = cls_new;
      wr_data.cnt = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear_wr || ctrl.commit) mem[idx] <= wr_data;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      delay_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctrl.clear_wr || ctrl.advance) begin
      idx <= idx_inc;
    end else if (ctrl.start_probe) begin
      idx <= POW2 ? hx[IDX_W-1:0] : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      addr       <= caller_address;
      match      <= module_matches;
      hx         <= hash_in;
      rem        <= '0;
      step       <= '0;
      pend_delay <= 1'b0;
      pend_full  <= 1'b0;
      pend_fresh <= 1'b0;
    end else if (ctrl.hash_step) begin
      hx   <= hx << HASH_DIGIT;
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
    if (ctrl.start_probe) probes <= '0;
    else if (ctrl.advance) probes <= probes + IDX_W'(1);
    if (ctrl.commit) begin
      pend_delay <= delay_now;
      pend_fresh <= fresh;
    end else if (ctrl.set_full) begin
      pend_full <= 1'b1;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_delay <= pend_delay;
      out_full  <= pend_full;
      out_fresh <= pend_fresh;
    end
  end

  assign result.valid            = out_valid;
  assign result.delay            = out_delay;
  assign result.table_full       = out_full;
  assign result.newly_classified = out_fresh;

  assign stat.clear_last = (idx == IDX_LAST);
  assign stat.qualifies  = call_ok && is_monotonic && (caller_address != '0);
  assign stat.hash_done  = POW2 || (step == STEP_W'(HASH_STEPS));
  assign stat.hit        = key_empty || key_hit;
  assign stat.last_probe = (probes == IDX_LAST);
  assign stat.out_free   = !out_valid || result.ready;

endmodule

### design/csdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdf_ctrl: sequencer for the call-site delay filter
// Clearing pass, hash, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module csdf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  csdf_pkg::stat_t stat,
  output csdf_pkg::ctrl_t ctrl
);
  import csdf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = stat.qualifies ? ST_HASH : ST_DONE;
      ST_HASH:  if (stat.hash_done) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.hit || stat.last_probe) state_next = ST_DONE;
        else                             state_next = ST_READ;
      end
      ST_DONE:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: ctrl.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctrl.load_item = in_valid;
      end
      ST_HASH: begin
        ctrl.start_probe = stat.hash_done;
        ctrl.hash_step   = !stat.hash_done;
      end
      ST_READ: ;
      ST_CHECK: begin
        ctrl.commit   = stat.hit;
        ctrl.set_full = !stat.hit && stat.last_probe;
        ctrl.advance  = !stat.hit && !stat.last_probe;
      end
      ST_DONE:  ctrl.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

### design/call_site_delay_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_site_delay_filter_unit: per-call-site delay decision for timer queries
// Linear-probe hash table of call sites with a saturating per-site counter.
// ----------------------------------------------------------------------------
// Usage:
//   query  - valid/ready sink, one timer query per transfer.
//   result - valid/ready source, exactly one decision per query, in order.
//   cfg_wr_en/cfg_wr_data - write of delay_limit; write only while idle.
// Flow (one query at a time):
//   Non-qualifying query: goes from idle straight to the done state, which
//   loads the result register; the next query is taken back in idle.
//   Qualifying query, SLOTS a power of two: hash, then P probes, then the
//   done state, P = slots probed (1..SLOTS); each probe is one read of
//   the single-port slot memory (read state) plus a compare (check state).
//   SLOTS not a power of two: the hash is reduced mod SLOTS one 4-bit digit a
//   cycle in the hash state, before the first probe.
// Reset: clears the delay limit to 512 and then sweeps the slot memory to
//   zero, one slot a cycle, while query.ready stays low.
// Stall: the result sits in an output register; a stalled receiver holds the
//   sequencer in its final state until the register frees up, so at most one
//   finished decision waits while the next query is being worked.
// ----------------------------------------------------------------------------
module call_site_delay_filter_unit #(
  parameter int SLOTS = csdf_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [csdf_pkg::LIMIT_W-1:0] cfg_wr_data,
  csdf_query_if.sink                   query,
  csdf_result_if.source                result
);
  import csdf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  assign query.ready = in_ready;

  // sequencer: clear sweep, hash, probe loop, hand-off
  csdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (query.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // slot memory, hash reduction, limit register, output stage
  csdf_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .caller_address (query.caller_address),
    .call_ok        (query.call_ok),
    .is_monotonic   (query.is_monotonic),
    .module_matches (query.module_matches),
    .ctrl           (ctrl),
    .stat           (stat),
    .result         (result)
  );

  // no query taken right after reset: the clearing sweep runs first
  a_no_accept_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !query.ready)
    else $error("query ready during clearing sweep");

  // one query at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (query.valid && query.ready) |=> !query.ready)
    else $error("query taken while another is in progress");

  // a taken result is not shown again unless a new one is loaded
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !ctrl.emit) |=> !result.valid)
    else $error("result repeated");

  // a full table never delays
  a_full_no_delay: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.delay && result.table_full))
    else $error("delay reported with full table");

endmodule

### sim/tb_call_site_delay_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_call_site_delay_filter_unit: self-checking bench of the delay filter
// Drives timer queries through the query channel and checks every decision
// against a bit-accurate site-table predictor. Covers non-qualifying queries,
// probe collisions and wrap, class stickiness, limit extremes, count
// saturation and a completely full table, under random bursts and stalls.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic delay;
  logic table_full;
  logic newly_classified;
} decision_t;

// Site table predictor: mirrors the probe table and queues due decisions.
class site_delay_predictor;
  localparam int SITE_SLOTS = csdf_pkg::SLOTS_DEF;

  logic [csdf_pkg::ADDR_W-1:0]  site_key   [SITE_SLOTS];
  logic [csdf_pkg::CLASS_W-1:0] site_class [SITE_SLOTS];
  logic [csdf_pkg::CNT_W-1:0]   site_count [SITE_SLOTS];
  logic [csdf_pkg::LIMIT_W-1:0] limit;
  decision_t                    decisions_due[$];
  int                           sites_used;
  int                           errors;

  function new();
    for (int i = 0; i < SITE_SLOTS; i++) begin
      site_key[i]   = '0;
      site_class[i] = csdf_pkg::CLASS_NONE;
      site_count[i] = '0;
    end
    limit      = csdf_pkg::LIMIT_RESET;
    sites_used = 0;
    errors     = 0;
  endfunction

  function int pending();
    return decisions_due.size();
  endfunction

  // Predict the decision of one accepted query and update the table.
  function void note_query(logic [csdf_pkg::ADDR_W-1:0] addr, logic ok, logic mono,
                           logic mod_match);
    decision_t d;
    int        start;
    int        probe;
    int        hit;
    d   = '0;
    hit = -1;
    if (ok && mono && addr != '0) begin
      start = int'(((addr >> 4) ^ (addr >> 13)) % SITE_SLOTS);
      for (int n = 0; n < SITE_SLOTS && hit < 0; n++) begin
        probe = (start + n) % SITE_SLOTS;
        if (site_key[probe] == '0) begin
          site_key[probe] = addr;
          sites_used++;
          hit = probe;
        end else if (site_key[probe] == addr) begin
          hit = probe;
        end
      end
      if (hit < 0) begin
        d.table_full = 1'b1;
      end else begin
        if (site_class[hit] == csdf_pkg::CLASS_NONE) begin
          site_class[hit] = mod_match ? csdf_pkg::CLASS_MATCH : csdf_pkg::CLASS_OTHER;
          d.newly_classified = 1'b1;
        end
        if (site_class[hit] == csdf_pkg::CLASS_MATCH) begin
          d.delay = (site_count[hit] < limit);
          if (site_count[hit] != csdf_pkg::CNT_MAX) site_count[hit] = site_count[hit] + 1'b1;
        end
      end
    end
    decisions_due.push_back(d);
  endfunction

  function void check_decision(decision_t got);
    decision_t want;
    if (decisions_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("decision with none due: delay=%0b full=%0b new=%0b",
                 got.delay, got.table_full, got.newly_classified);
      return;
    end
    want = decisions_due.pop_front();
    if (got.delay !== want.delay || got.table_full !== want.table_full ||
        got.newly_classified !== want.newly_classified) begin
      errors++;
      if (errors <= 10)
        $display("decision mismatch: want delay=%0b full=%0b new=%0b, got %0b %0b %0b",
                 want.delay, want.table_full, want.newly_classified,
                 got.delay, got.table_full, got.newly_classified);
    end
  endfunction
endclass

module tb_call_site_delay_filter_unit;
  import csdf_pkg::*;

  localparam int SITES        = SLOTS_DEF;
  // Worst case is a full table walk per query plus stalls and gaps, for
  // roughly 1800 queries; several times that as a hang guard.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int POOL_CAP     = 120;

  logic clk;
  logic rst;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  csdf_query_if  query_ch ();
  csdf_result_if result_ch ();

  call_site_delay_filter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .query       (query_ch),
    .result      (result_ch)
  );

  site_delay_predictor predictor;

  // Call sites seen so far; random traffic mostly revisits these.
  logic [ADDR_W-1:0] site_pool[$];
  int                burst_left;
  longint            cycles;

  // --------------------------------------------------------------------------
  // Clock and cycle guard
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_call_site_delay_filter_unit failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decision receiver: checks each transfer, stalls on its own pattern.
  // Mode is re-picked window by window: always ready, random drops,
  // 3-on/1-off, or mostly stalled (ready one eighth of the time).
  // --------------------------------------------------------------------------
  initial begin
    int        mode;
    int        window;
    int        phase_cnt;
    decision_t got;
    result_ch.ready <= 1'b0;
    mode      = 0;
    window    = 0;
    phase_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.delay            = result_ch.delay;
        got.table_full       = result_ch.table_full;
        got.newly_classified = result_ch.newly_classified;
        predictor.check_decision(got);
      end
      if (window == 0) begin
        mode   = $urandom_range(0, 3);
        window = 40;
      end
      window--;
      phase_cnt++;
      case (mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 3) != 0);
        2: result_ch.ready <= ((phase_cnt % 4) != 0);
        default: result_ch.ready <= ((phase_cnt % 8) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Query sender
  // --------------------------------------------------------------------------
  function int next_burst();
    // Mostly short bursts, now and then a long stretch with no idle cycles.
    return ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
  endfunction

  // One query transfer. Valid stays up across a burst; after a burst the
  // sender idles so valid is never lowered and raised in one step.
  task automatic send_query(logic [ADDR_W-1:0] addr, logic ok, logic mono, logic mod_match);
    query_ch.valid          <= 1'b1;
    query_ch.caller_address <= addr;
    query_ch.call_ok        <= ok;
    query_ch.is_monotonic   <= mono;
    query_ch.module_matches <= mod_match;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    predictor.note_query(addr, ok, mono, mod_match);
    burst_left--;
    if (burst_left <= 0) begin
      query_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = next_burst();
    end
  endtask

  // Qualifying query shorthand.
  task automatic hit_site(logic [ADDR_W-1:0] addr, logic mod_match);
    send_query(addr, 1'b1, 1'b1, mod_match);
  endtask

  // Stop sending and wait for every due decision; the block is idle then.
  task automatic settle();
    query_ch.valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Limit write, only ever issued after settle().
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    predictor.limit = value;
    @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] fresh_addr();
    logic [ADDR_W-1:0] a;
    a = {$urandom, $urandom};
    if (a == '0) a = 64'h1234;
    return a;
  endfunction

  // Random traffic: mostly revisits of known sites with a random match flag,
  // some new sites (half of them colliding with a known one), some noise.
  task automatic random_traffic(int n_items);
    int                r;
    logic [ADDR_W-1:0] a;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // Noise: address may be zero; the flags rarely both qualify.
        a = ($urandom_range(0, 2) == 0) ? '0 : site_pool[$urandom_range(0, site_pool.size() - 1)];
        send_query(a, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (r < 27 && site_pool.size() < POOL_CAP) begin
        if ($urandom_range(0, 1) == 0) begin
          // Same bits 20:4 as a known site, so the probe start collides.
          a = site_pool[$urandom_range(0, site_pool.size() - 1)] ^
              (64'($urandom_range(1, 255)) << 56);
          if (a == '0) a = fresh_addr();
        end else begin
          a = fresh_addr();
        end
        site_pool.push_back(a);
        hit_site(a, $urandom_range(0, 1));
      end else begin
        hit_site(site_pool[$urandom_range(0, site_pool.size() - 1)], $urandom_range(0, 1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] site_a;
    logic [ADDR_W-1:0] site_c;
    logic [ADDR_W-1:0] hot;
    logic [ADDR_W-1:0] wrap_site [4];

    predictor = new();
    rst                     <= 1'b1;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= '0;
    query_ch.valid          <= 1'b0;
    query_ch.caller_address <= '0;
    query_ch.call_ok        <= 1'b0;
    query_ch.is_monotonic   <= 1'b0;
    query_ch.module_matches <= 1'b0;
    burst_left = next_burst();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed, reset limit of 512 ---------------------------------------
    site_a = fresh_addr();
    // Starts at slot 255 so the probe wraps past slot 0.
    for (int k = 0; k < 4; k++) wrap_site[k] = 64'h0FF0 | (64'(k + 1) << 40);

    // Non-qualifying: each disqualifier on its own, then both flags low, then all zero.
    send_query(site_a, 1'b0, 1'b1, 1'b1);
    send_query(site_a, 1'b1, 1'b0, 1'b1);
    send_query('0, 1'b1, 1'b1, 1'b1);
    send_query('1, 1'b0, 1'b0, 1'b0);
    send_query('0, 1'b0, 1'b0, 1'b0);
    // Highest address, matching; then the class sticks despite a clear flag.
    hit_site('1, 1'b1);
    hit_site('1, 1'b0);
    // Non-matching site never delays, even when the flag flips later.
    hit_site(site_a, 1'b0);
    hit_site(site_a, 1'b1);
    // Lowest non-zero address hashes to slot 0, held by the highest address, so it probes on.
    hit_site(64'h1, 1'b1);
    // Collision cluster at the top slot: wraps and probes past slot 0.
    for (int k = 0; k < 4; k++) hit_site(wrap_site[k], k[0]);
    for (int k = 3; k >= 0; k--) hit_site(wrap_site[k], ~k[0]);
    hit_site(64'h8000_0000_0000_0000, 1'b1);
    settle();

    // ---- Limit extremes -------------------------------------------------------
    write_limit('0);                         // no site may delay
    hit_site('1, 1'b1);
    hit_site(64'h1, 1'b1);
    site_c = fresh_addr();
    settle();
    write_limit(LIMIT_W'(1));                // exactly one delayed call
    hit_site(site_c, 1'b1);
    hit_site(site_c, 1'b1);
    settle();
    write_limit('1);
    hit_site('1, 1'b0);
    settle();

    site_pool.push_back(site_a);
    site_pool.push_back(site_c);
    site_pool.push_back(64'h1);
    site_pool.push_back('1);
    for (int k = 0; k < 4; k++) site_pool.push_back(wrap_site[k]);

    // ---- Count saturation: limit 1023, one site hammered past 1023 calls ----
    // Delay must drop after the 1023rd call and stay off (no wrap to zero).
    hot = fresh_addr();
    hit_site(hot, 1'b1);
    repeat (1030) hit_site(hot, $urandom_range(0, 1));
    settle();
    site_pool.push_back(hot);

    // ---- Random traffic under several limits ---------------------------------
    write_limit(LIMIT_W'(1));
    random_traffic(100);
    settle();
    write_limit(LIMIT_W'($urandom_range(2, 5)));
    random_traffic(100);
    settle();
    write_limit(LIMIT_W'($urandom_range(0, 1023)));
    random_traffic(100);
    settle();
    write_limit(LIMIT_W'(3));
    random_traffic(100);
    settle();

    // ---- Fill the table, then query with it full ------------------------------
    write_limit(LIMIT_W'($urandom_range(1, 4)));
    while (predictor.sites_used < SITES) hit_site(fresh_addr(), $urandom_range(0, 1));
    // New sites find no slot; known sites are still found after long probes.
    repeat (8) hit_site(fresh_addr(), $urandom_range(0, 1));
    hit_site(hot, 1'b1);
    hit_site(wrap_site[3], 1'b0);
    hit_site(site_c, 1'b1);
    send_query(fresh_addr(), 1'b1, 1'b0, 1'b1);
    hit_site('0, 1'b1);
    repeat (4) hit_site(fresh_addr(), 1'b1);
    settle();

    // Let any stray transfer show up before the verdict.
    repeat (30) @(posedge clk);
    if (predictor.errors == 0) begin
      $display("tb_call_site_delay_filter_unit passed");
    end else begin
      $display("tb_call_site_delay_filter_unit failed");
    end
    $finish;
  end

endmodule
